// ----- design/frbc_pkg.sv -----
// shared constants, types and the crc byte update for the flash record checker
package frbc_pkg;

  localparam int RECORD_BYTES = 64;
  localparam int POS_W        = $clog2(RECORD_BYTES);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(RECORD_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(RECORD_BYTES - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_WANTED_ID = 1'b0;

  typedef enum logic [2:0] {
    OP_FIRST  = 3'd0,
    OP_SECOND = 3'd1,
    OP_BODY   = 3'd2,
    OP_CRC_LO = 3'd3,
    OP_LAST   = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
  } frbc_op_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/frbc_front.sv -----
// front end: tracks the byte position and tags each word with its role in the record
module frbc_front
  import frbc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           block_start,
  output frbc_op_t       op
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] pos;

  assign pos = block_start ? '0 : pos_r;

  always_comb begin
    op.data = data_byte;
    unique if (pos == '0) begin
      op.kind = OP_FIRST;
    end else if (pos == POS_W'(1)) begin
      op.kind = OP_SECOND;
    end else if (pos == POS_CRC_LO) begin
      op.kind = OP_CRC_LO;
    end else if (pos == POS_LAST) begin
      op.kind = OP_LAST;
    end else begin
      op.kind = OP_BODY;
    end
  end

  assign pos_nxt = (pos == POS_LAST) ? '0 : pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- design/frbc_queue.sv -----
// short queue of tagged words between front and back
module frbc_queue
  import frbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  frbc_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output frbc_op_t head_op
);

  frbc_op_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head_op  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- design/frbc_back.sv -----
// back end: crc update, id capture, final compare and result register
module frbc_back
  import frbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  frbc_op_t    op,
  output logic        op_pop,
  input  logic [15:0] wanted_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_record_id,
  output logic        out_id_match,
  output logic        out_crc_ok,
  output logic [15:0] out_computed_crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] id_r;
  logic [7:0]  crc_lo_r;
  logic        out_valid_r;
  logic [15:0] res_id_r;
  logic        res_match_r;
  logic        res_ok_r;
  logic [15:0] res_crc_r;
  logic        out_free;
  logic [15:0] computed;
  logic [15:0] crc_base;

  // the result register frees up in the same cycle it is taken
  assign out_free = !out_valid_r || !out_stall;
  assign op_pop   = op_valid && ((op.kind != OP_LAST) || out_free);

  assign crc_base = (op.kind == OP_FIRST) ? CRC_INIT : crc_r;
  assign crc_nxt  = crc_byte(crc_base, op.data);
  assign computed = ~crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      id_r     <= '0;
      crc_lo_r <= '0;
    end else if (op_pop) begin
      unique case (op.kind)
        OP_FIRST: begin
          crc_r     <= crc_nxt;
          id_r[7:0] <= op.data;
        end
        OP_SECOND: begin
          crc_r      <= crc_nxt;
          id_r[15:8] <= op.data;
        end
        OP_BODY: begin
          crc_r <= crc_nxt;
        end
        OP_CRC_LO: begin
          crc_lo_r <= op.data;
        end
        OP_LAST: begin
          crc_r <= CRC_INIT;
        end
        default: begin
          crc_r <= crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_pop && (op.kind == OP_LAST)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && (op.kind == OP_LAST)) begin
      res_id_r    <= id_r;
      res_match_r <= (id_r == wanted_id);
      res_ok_r    <= (computed == {op.data, crc_lo_r});
      res_crc_r   <= computed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_id    = res_id_r;
  assign out_id_match     = res_match_r;
  assign out_crc_ok       = res_ok_r;
  assign out_computed_crc = res_crc_r;

endmodule

// ----- design/flash_record_block_checker.sv -----
// top level of the flash record checker: config register, front, queue and back
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid/in_stall   | in_data_byte[7:0], in_block_start
//  out      | out_valid/out_stall | out_record_id, out_id_match, out_crc_ok,
//           |                     | out_computed_crc
//  config   | psel/penable/pwrite | paddr[2:0], pwdata/prdata[31:0], pready
//
// one byte per cycle while in_stall is low; a record of 64 bytes yields one result word
// back end: one queued byte a cycle (bar an out_stall hold) through a byte-wide crc update
// out_valid comes from the result register, loaded as the back end pops the last byte
// reset clears the byte position, the queue and the result valid; no clearing pass
// in_stall rises only when the four-entry queue is full; out_stall holds back
// only the last byte of a record, the bytes ahead of it keep draining
module flash_record_block_checker
  import frbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_block_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_record_id,
  output logic                  out_id_match,
  output logic                  out_crc_ok,
  output logic [15:0]           out_computed_crc,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0] wanted_id_r;
  logic        in_accept;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  frbc_op_t    front_op;
  frbc_op_t    head_op;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_id_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WANTED_ID)) begin
      wanted_id_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_WANTED_ID) ? {16'h0000, wanted_id_r} : '0;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  frbc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .block_start (in_block_start),
    .op          (front_op)
  );

  frbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_op  (front_op),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_op  (head_op)
  );

  frbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (q_nonempty),
    .op               (head_op),
    .op_pop           (q_pop),
    .wanted_id        (wanted_id_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_id    (out_record_id),
    .out_id_match     (out_id_match),
    .out_crc_ok       (out_crc_ok),
    .out_computed_crc (out_computed_crc)
  );

endmodule

// ----- design/frbc_checker.sv -----
// port-level checks for the flash record checker, bound to the top level
module frbc_checker
  import frbc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_record_id,
  input logic [15:0] out_computed_crc,
  input logic        pready
);

  // a held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_record_id) && $stable(out_computed_crc))
    else $error("result word changed while stalled");

  // reset empties the result register and the queue
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall && pready)
    else $error("input stalled or config not ready after reset");

endmodule

bind flash_record_block_checker frbc_checker u_frbc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_record_id    (out_record_id),
  .out_computed_crc (out_computed_crc),
  .pready           (pready)
);

// ----- bench/record_verdict_pkg.sv -----
`timescale 1ns / 100ps
// expected result words of the flash record checker, tracked byte by byte
package record_verdict_pkg;
  import frbc_pkg::*;

  localparam int          REC_LEN  = RECORD_BYTES;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_GEN  = 16'h1021;

  typedef struct packed {
    logic [15:0] record_id;
    logic        id_match;
    logic        crc_ok;
    logic [15:0] computed_crc;
  } record_verdict_t;

  class record_verdict_tracker;
    logic [15:0]     crc_run;
    int              byte_idx;
    logic [15:0]     id_seen;
    logic [7:0]      crc_lo_seen;
    logic [15:0]     wanted_id;
    record_verdict_t pending_verdicts[$];
    int              errors;

    function new();
      crc_run     = CRC_SEED;
      byte_idx    = 0;
      id_seen     = '0;
      crc_lo_seen = '0;
      wanted_id   = '0;
      errors      = 0;
    endfunction

    // one data bit at a time, msb first
    static function logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ b[k];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_GEN;
        end
      end
      return c;
    endfunction

    function void take_byte(input logic [7:0] d, input logic s);
      record_verdict_t v;
      logic [15:0]     crc_final;
      if (s) begin
        byte_idx = 0;
        crc_run  = CRC_SEED;
      end
      if (byte_idx == 0) begin
        id_seen[7:0] = d;
      end else if (byte_idx == 1) begin
        id_seen[15:8] = d;
      end
      if (byte_idx < REC_LEN - 2) begin
        crc_run = crc_update(crc_run, d);
        byte_idx++;
      end else if (byte_idx == REC_LEN - 2) begin
        crc_lo_seen = d;
        byte_idx++;
      end else begin
        crc_final      = ~crc_run;
        v.record_id    = id_seen;
        v.id_match     = (id_seen == wanted_id);
        v.crc_ok       = (crc_final == {d, crc_lo_seen});
        v.computed_crc = crc_final;
        pending_verdicts.push_back(v);
        byte_idx = 0;
        crc_run  = CRC_SEED;
      end
    endfunction

    function void check_verdict(input logic [15:0] rid, input logic im, input logic ok,
                                input logic [15:0] crc);
      record_verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word: record_id %h computed_crc %h", rid, crc);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.record_id !== rid) begin
        $error("record_id: expected %h, got %h", want.record_id, rid);
        errors++;
      end
      if (want.id_match !== im) begin
        $error("id_match: expected %b, got %b", want.id_match, im);
        errors++;
      end
      if (want.crc_ok !== ok) begin
        $error("crc_ok: expected %b, got %b", want.crc_ok, ok);
        errors++;
      end
      if (want.computed_crc !== crc) begin
        $error("computed_crc: expected %h, got %h", want.computed_crc, crc);
        errors++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

endpackage

// ----- bench/flash_record_block_checker_tb.sv -----
`timescale 1ns / 100ps
// testbench top: drives records through the flash record checker and checks each verdict
module flash_record_block_checker_tb;
  import frbc_pkg::*;
  import record_verdict_pkg::*;

  typedef enum int {START_OFF, START_ON, START_AUTO} start_mode_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 220;
  localparam logic [CFG_ADDR_W-1:0] WANTED_ID_ADDR = CFG_ADDR_W'(4 * int'(REG_WANTED_ID));

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_data_byte;
  logic                  in_block_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_record_id;
  logic                  out_id_match;
  logic                  out_crc_ok;
  logic [15:0]           out_computed_crc;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  record_verdict_tracker verdicts;
  int                    quiet_cycles = 0;
  int                    drv_pos;
  int                    bytes_sent;
  int                    in_gap_pct;
  int                    out_stall_pct;
  bit                    calm;
  logic [15:0]           wanted_now;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flash_record_block_checker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_block_start   (in_block_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_id    (out_record_id),
    .out_id_match     (out_id_match),
    .out_crc_ok       (out_crc_ok),
    .out_computed_crc (out_computed_crc),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // both channels sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        verdicts.take_byte(in_data_byte, in_block_start);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        verdicts.check_verdict(out_record_id, out_id_match, out_crc_ok, out_computed_crc);
      end
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("flash_record_block_checker regression: fail");
        $finish;
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic s);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_block_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s) begin
      drv_pos = 0;
    end
    drv_pos = (drv_pos == REC_LEN - 1) ? 0 : drv_pos + 1;
    bytes_sent++;
  endtask

  task automatic send_record(input logic [15:0] id, input bit crc_good, input fill_kind_t fill,
                             input start_mode_t mode);
    logic [7:0]  rec [REC_LEN];
    logic [15:0] crc;
    logic        first_flag;
    rec[0] = id[7:0];
    rec[1] = id[15:8];
    for (int i = 2; i < REC_LEN - 2; i++) begin
      case (fill)
        FILL_ZERO: rec[i] = 8'h00;
        FILL_ONES: rec[i] = 8'hFF;
        default:   rec[i] = 8'($urandom);
      endcase
    end
    crc = CRC_SEED;
    for (int i = 0; i < REC_LEN - 2; i++) begin
      crc = record_verdict_tracker::crc_update(crc, rec[i]);
    end
    crc = ~crc;
    // one flipped bit gives a stored crc that cannot match
    if (!crc_good) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    rec[REC_LEN-2] = crc[7:0];
    rec[REC_LEN-1] = crc[15:8];
    case (mode)
      START_OFF: first_flag = 1'b0;
      START_ON:  first_flag = 1'b1;
      default:   first_flag = (drv_pos != 0) || ($urandom_range(0, 1) == 1);
    endcase
    send_byte(rec[0], first_flag);
    for (int i = 1; i < REC_LEN; i++) begin
      send_byte(rec[i], 1'b0);
    end
  endtask

  // a record cut short; the next start flag drops it
  task automatic send_broken(input int len);
    send_byte(8'($urandom), 1'b1);
    repeat (len - 1) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic write_wanted(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WANTED_ID_ADDR;
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== v) begin
      $error("wanted_block_id: expected %h, got %h", v, prdata[15:0]);
      verdicts.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    verdicts.wanted_id = v;
    wanted_now         = v;
  endtask

  // wait out every expected word, then the queue behind it
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return wanted_now;
      5:             return 16'h0000;
      6:             return 16'hFFFF;
      default:       return 16'($urandom);
    endcase
  endfunction

  initial begin
    verdicts       = new();
    calm           = 1'b0;
    in_gap_pct     = 20;
    out_stall_pct  = 20;
    drv_pos        = 0;
    bytes_sent     = 0;
    wanted_now     = '0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_block_start <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // no start flag after reset, then a wrap straight into the next record
    send_record(16'h0000, 1'b1, FILL_ZERO, START_OFF);
    send_record(16'hFFFF, 1'b1, FILL_ONES, START_OFF);
    send_record(16'h1234, 1'b0, FILL_RANDOM, START_ON);
    send_broken(REC_LEN - 1);
    send_record(16'h00FF, 1'b1, FILL_RANDOM, START_ON);
    send_broken(1);
    send_record(16'hFF00, 1'b0, FILL_ONES, START_ON);
    wait_drained();
    write_wanted(16'hFFFF);
    send_record(16'hFFFF, 1'b1, FILL_ZERO, START_AUTO);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      int         stop_at;
      int         pick;
      fill_kind_t fill;
      calm          = (p == PHASES - 1);
      in_gap_pct    = $urandom_range(0, 2) * 20;
      out_stall_pct = $urandom_range(0, 2) * 20;
      if (p == 1) begin
        write_wanted(16'h0000);
      end else if (p == 2) begin
        write_wanted(16'hFFFF);
      end else begin
        write_wanted(16'($urandom));
      end
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 9);
        fill = FILL_RANDOM;
        if ($urandom_range(0, 15) == 0) begin
          fill = ($urandom_range(0, 1) == 1) ? FILL_ZERO : FILL_ONES;
        end
        if (pick < 7) begin
          send_record(pick_id(), $urandom_range(0, 4) != 0, fill, START_AUTO);
        end else if (pick < 9) begin
          send_broken($urandom_range(1, REC_LEN - 1));
        end else begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
      end
      wait_drained();
    end

    if (verdicts.errors == 0) begin
      $display("flash_record_block_checker regression: pass");
    end else begin
      $display("flash_record_block_checker regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/frbc_pkg.sv
design/frbc_front.sv
design/frbc_queue.sv
design/frbc_back.sv
design/flash_record_block_checker.sv
design/frbc_checker.sv
bench/record_verdict_pkg.sv
bench/flash_record_block_checker_tb.sv
